// ----- rtl/core/mbch_pkg.sv -----
// shared constants, codes and types of the masked box colour histogram
package mbch_pkg;

    // channel quantisation and default sizes
    localparam int LEVELS_PER_CHANNEL = 16;
    localparam int LEVEL_BITS         = 4;
    localparam int BIN_TOTAL_DEF      = 4096;
    localparam int COORD_BITS_DEF     = 11;
    localparam int COUNT_BITS_DEF     = 22;

    // raw bin sum and read index both span this many bits
    localparam int BIN_RAW_BITS = 12;

    // image size after reset
    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int OP_BITS     = 2;

    // configuration port
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_BOX_WIDTH    = 3'd2,
        CFG_BOX_HEIGHT   = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } cfg_reg_t;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // commands handed to the back end
    typedef enum logic [OP_BITS-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2
    } cmd_op_t;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_PIX_WR,
        BK_RESP
    } back_state_t;

    // status from back end to front end
    typedef struct packed {
        logic init_busy;
        logic sweeping;
    } back_status_t;

endpackage

// ----- rtl/core/mbch_if.sv -----
// handshake channels of the masked box colour histogram

// input item channel
interface mbch_in_if
    import mbch_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [COORD_BITS-1:0]   col;
    logic [COORD_BITS-1:0]   row;
    logic                    fg_mask;
    logic [LEVEL_BITS-1:0]   blue_bin;
    logic [LEVEL_BITS-1:0]   green_bin;
    logic [LEVEL_BITS-1:0]   red_bin;
    logic [BIN_RAW_BITS-1:0] read_index;

    modport source (
        output valid, kind, col, row, fg_mask, blue_bin, green_bin, red_bin, read_index,
        input  ready
    );
    modport sink (
        input  valid, kind, col, row, fg_mask, blue_bin, green_bin, red_bin, read_index,
        output ready
    );
endinterface

// result channel
interface mbch_out_if
    import mbch_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] bin_count;
    logic [COUNT_BITS-1:0] pixel_total;

    modport source (
        output valid, bin_count, pixel_total,
        input  ready
    );
    modport sink (
        input  valid, bin_count, pixel_total,
        output ready
    );
endinterface

// configuration write channel
interface mbch_cfg_if
    import mbch_pkg::*;
#(
    parameter int DATA_BITS = COORD_BITS_DEF + 1
);
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/core/masked_box_color_histogram_unit.sv -----
// top level of the masked box colour histogram
//
// Counts foreground pixels that fall inside a box around a centre point,
// clipped to the image, into BIN_TOTAL colour bins (blue + 16*green +
// 256*red) plus a pixel total, both saturating. The front end takes one item
// per cycle while the queue has room, into a two-entry command queue; pixels
// outside the box, background pixels and unused kinds are dropped there and
// cost nothing further. The back end works on one command at a time on a bin
// memory with a write port and a registered read port: a counted pixel is read
// and written back, a read item is read and waits for the result register, a
// clear item runs the zeroing sweep. After reset the same sweep covers all
// BIN_TOTAL bins (4096 by default) with in_ch.ready low; configuration writes
// are taken at any time. Results appear only for read items.
module masked_box_color_histogram_unit
    import mbch_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int BIN_TOTAL  = BIN_TOTAL_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mbch_in_if.sink    in_ch,
    mbch_cfg_if.sink   cfg_ch,
    mbch_out_if.source out_ch
);

    localparam int CMD_W = OP_BITS + $clog2(BIN_TOTAL);

    back_status_t     status;
    logic             q_push;
    logic [CMD_W-1:0] q_push_data;
    logic             q_full;
    logic             q_pop;
    logic [CMD_W-1:0] q_pop_data;
    logic             q_empty;

    // front end
    mbch_front #(
        .COORD_BITS (COORD_BITS),
        .BIN_TOTAL  (BIN_TOTAL)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .status (status),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    // command queue
    mbch_cmd_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // back end
    mbch_back #(
        .COUNT_BITS (COUNT_BITS),
        .BIN_TOTAL  (BIN_TOTAL)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .status  (status),
        .out_ch  (out_ch)
    );

    // back end only pops a queue that holds a command
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    // no result can be pending during the reset clearing pass
    assert property (@(posedge clk) disable iff (!rst_n) status.init_busy |-> !out_ch.valid)
        else $error("result offered during the reset clearing pass");

    // an item of unused kind never reaches the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.kind != KIND_CLEAR
            && in_ch.kind != KIND_PIXEL && in_ch.kind != KIND_READ) |-> !q_push)
        else $error("unused item kind queued");

    // the queue is never written while the reset sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.init_busy && status.sweeping) |-> !q_push)
        else $error("command queued during the reset clearing pass");

endmodule

// ----- rtl/core/mbch_cmd_queue.sv -----
// short command queue between the front and back ends
module mbch_cmd_queue
    import mbch_pkg::*;
#(
    parameter int WIDTH = OP_BITS + 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/mbch_front.sv -----
// front end: configuration registers, box test and bin index, command issue
module mbch_front
    import mbch_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int BIN_TOTAL  = BIN_TOTAL_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    mbch_in_if.sink                                  in_ch,
    mbch_cfg_if.sink                                 cfg_ch,
    input  back_status_t                             status,
    input  logic                                     q_full,
    output logic                                     q_push,
    output logic [OP_BITS+$clog2(BIN_TOTAL)-1:0]     q_data
);

    localparam int CW        = COORD_BITS;
    localparam int SW        = COORD_BITS + 3;
    localparam int IDX_W     = $clog2(BIN_TOTAL);
    localparam int RAW_SPAN  = 1 << BIN_RAW_BITS;
    localparam int MOD_STEPS = $clog2((RAW_SPAN + BIN_TOTAL - 1) / BIN_TOTAL);
    localparam int MOD_W     = BIN_RAW_BITS + 1;

    logic [CW-1:0] center_x_reg;
    logic [CW-1:0] center_y_reg;
    logic [CW-1:0] box_width_reg;
    logic [CW-1:0] box_height_reg;
    logic [CW:0]   image_width_reg;
    logic [CW:0]   image_height_reg;

    logic                    accept;
    logic                    in_box;
    logic [BIN_RAW_BITS-1:0] pix_raw;
    logic [IDX_W-1:0]        pix_idx;
    logic [IDX_W-1:0]        read_idx;
    cmd_op_t                 op;
    logic [IDX_W-1:0]        idx;

    // clipped span test: pos in [max(0, c - s/2), min(c + s/2, lim - 1))
    function automatic logic in_span(
        input logic [CW-1:0] pos,
        input logic [CW-1:0] c,
        input logic [CW-1:0] s,
        input logic [CW:0]   lim
    );
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lim_m1;
        logic signed [SW-1:0] pos_s;
        lo     = $signed(SW'(c)) - $signed(SW'(s >> 1));
        hi     = $signed(SW'(c)) + $signed(SW'(s >> 1));
        lim_m1 = $signed(SW'(lim)) - $signed(SW'(1));
        pos_s  = $signed(SW'(pos));
        if (lo < $signed(SW'(0)))
        begin
            lo = '0;
        end
        if (hi >= lim_m1)
        begin
            hi = lim_m1;
        end
        return (pos_s >= lo) && (pos_s < hi);
    endfunction

    // remainder by the bin count through constant restoring steps
    function automatic logic [IDX_W-1:0] bin_wrap(input logic [BIN_RAW_BITS-1:0] raw);
        logic [MOD_W-1:0] v;
        v = MOD_W'(raw);
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (v >= MOD_W'(BIN_TOTAL << k))
            begin
                v = v - MOD_W'(BIN_TOTAL << k);
            end
        end
        return IDX_W'(v);
    endfunction

    // configuration writes
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            box_width_reg    <= '0;
            box_height_reg   <= '0;
            image_width_reg  <= (CW+1)'(IMAGE_WIDTH_RESET);
            image_height_reg <= (CW+1)'(IMAGE_HEIGHT_RESET);
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_CENTER_X:     center_x_reg     <= cfg_ch.data[CW-1:0];
                CFG_CENTER_Y:     center_y_reg     <= cfg_ch.data[CW-1:0];
                CFG_BOX_WIDTH:    box_width_reg    <= cfg_ch.data[CW-1:0];
                CFG_BOX_HEIGHT:   box_height_reg   <= cfg_ch.data[CW-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_ch.data[CW:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_ch.data[CW:0];
                default:
                begin
                end
            endcase
        end
    end

    // item acceptance: held off by a full queue and by the reset clearing pass
    assign in_ch.ready = !q_full && !status.init_busy;
    assign accept      = in_ch.valid && in_ch.ready;

    // box membership of a pixel
    assign in_box = in_ch.fg_mask
                 && in_span(in_ch.col, center_x_reg, box_width_reg, image_width_reg)
                 && in_span(in_ch.row, center_y_reg, box_height_reg, image_height_reg);

    // colour bin and read bin
    assign pix_raw  = BIN_RAW_BITS'(in_ch.blue_bin)
                    + BIN_RAW_BITS'(in_ch.green_bin * LEVELS_PER_CHANNEL)
                    + BIN_RAW_BITS'(in_ch.red_bin * (LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL));
    assign pix_idx  = bin_wrap(pix_raw);
    assign read_idx = bin_wrap(in_ch.read_index);

    // classify and issue
    always_comb
    begin
        q_push = 1'b0;
        op     = CMD_CLEAR;
        idx    = '0;
        unique case (in_ch.kind)
            KIND_CLEAR:
            begin
                q_push = accept;
                op     = CMD_CLEAR;
            end
            KIND_PIXEL:
            begin
                q_push = accept && in_box;
                op     = CMD_PIXEL;
                idx    = pix_idx;
            end
            KIND_READ:
            begin
                q_push = accept;
                op     = CMD_READ;
                idx    = read_idx;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    assign q_data = {op, idx};

endmodule

// ----- rtl/core/mbch_back.sv -----
// back end: bin memory, read-modify-write, clearing sweep and result register
module mbch_back
    import mbch_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int BIN_TOTAL  = BIN_TOTAL_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  logic [OP_BITS+$clog2(BIN_TOTAL)-1:0] q_data,
    output logic                                 q_pop,
    output back_status_t                         status,
    mbch_out_if.source                           out_ch
);

    localparam int IDX_W = $clog2(BIN_TOTAL);

    logic [COUNT_BITS-1:0] hist_mem [BIN_TOTAL];
    logic [COUNT_BITS-1:0] rd_data_reg;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;
    logic                  init_reg;
    logic                  init_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_BITS-1:0] out_bin_reg;
    logic [COUNT_BITS-1:0] out_bin_next;
    logic [COUNT_BITS-1:0] out_total_reg;
    logic [COUNT_BITS-1:0] out_total_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;

    cmd_op_t               head_op;
    logic [IDX_W-1:0]      head_idx;
    logic                  slot_free;

    assign head_op   = cmd_op_t'(q_data[OP_BITS+IDX_W-1 -: OP_BITS]);
    assign head_idx  = q_data[IDX_W-1:0];
    assign slot_free = !out_valid_reg || out_ch.ready;

    // sequencer: next state, memory control and result loading
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        init_next      = init_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_bin_next   = out_bin_reg;
        out_total_next = out_total_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = head_idx;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (head_op)
                        CMD_CLEAR:
                        begin
                            idx_next   = '0;
                            total_next = '0;
                            state_next = BK_SWEEP;
                        end
                        CMD_PIXEL:
                        begin
                            mem_re     = 1'b1;
                            idx_next   = head_idx;
                            state_next = BK_PIX_WR;
                        end
                        CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = BK_RESP;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (idx_reg == IDX_W'(BIN_TOTAL - 1))
                begin
                    init_next  = 1'b0;
                    state_next = BK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_PIX_WR:
            begin
                // saturating increment of the bin and the total
                mem_we     = 1'b1;
                mem_wdata  = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
                total_next = (total_reg == '1) ? total_reg : total_reg + 1'b1;
                state_next = BK_IDLE;
            end
            BK_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_bin_next   = rd_data_reg;
                    out_total_next = total_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SWEEP;
            idx_reg       <= '0;
            total_reg     <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_bin_reg   <= out_bin_next;
        out_total_reg <= out_total_next;
    end

    // bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= hist_mem[mem_raddr];
        end
    end

    assign status.init_busy  = init_reg;
    assign status.sweeping   = (state_reg == BK_SWEEP);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.bin_count   = out_bin_reg;
    assign out_ch.pixel_total = out_total_reg;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the masked box colour histogram unit
`timescale 1ns / 1ps

module tb
    import mbch_pkg::*;
();

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 9;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 12400;
    localparam int          RANDOM_PHASES = 10;
    localparam int          ITEMS_PER_PHASE = 80;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          IDLE_PERCENT  = 33;
    localparam logic [21:0] COUNT_MAX     = 22'h3FFFFF;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [10:0] col;
        logic [10:0] row;
        logic        fg;
        logic [3:0]  blue;
        logic [3:0]  green;
        logic [3:0]  red;
        logic [11:0] read_index;
    } hist_item_t;

    typedef struct {
        logic [21:0] bin_count;
        logic [21:0] pixel_total;
    } bin_reading_t;

    logic clk;
    logic rst_n;

    mbch_in_if  in_ch ();
    mbch_out_if out_ch ();
    mbch_cfg_if cfg_ch ();

    masked_box_color_histogram_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    // stimulus and prediction state
    hist_item_t   pending_items [$];
    bin_reading_t expected_readings [$];
    logic [21:0]  bin_model [4096];
    logic [21:0]  total_model;
    int           cfg_model [6];
    int           stim_cfg [6];
    logic [11:0]  hot_bins [8];

    bit in_taken;
    bit steady;
    bit hold_done;
    int hold_left;
    int cycle_count;
    int mismatches;
    int items_accepted;
    int reads_checked;
    int pixels_counted;
    int clears_seen;
    int phases_run;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // true when pos lies in the box span clipped to [0, lim - 1)
    function automatic bit span_hit(int pos, int c, int s, int lim);
        int half;
        int lo;
        int hi;
        int lim_edge;
        half     = s / 2;
        lo       = c - half;
        hi       = c + half;
        lim_edge = lim - 1;
        if (lo < 0)
            lo = 0;
        if (hi >= lim_edge)
            hi = lim_edge;
        return (pos >= lo) && (pos < hi);
    endfunction

    function automatic logic [21:0] sat_inc(logic [21:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 22'd1;
    endfunction

    // update the histogram copy for one accepted item
    task automatic predict_item(input hist_item_t it);
        logic [11:0]  idx;
        bin_reading_t rd;
        case (it.kind)
            KIND_CLEAR:
            begin
                for (int i = 0; i < 4096; i++)
                    bin_model[i] = '0;
                total_model = '0;
                clears_seen++;
            end
            KIND_PIXEL:
            begin
                if (it.fg
                    && span_hit(int'(it.col), cfg_model[CFG_CENTER_X],
                                cfg_model[CFG_BOX_WIDTH], cfg_model[CFG_IMAGE_WIDTH])
                    && span_hit(int'(it.row), cfg_model[CFG_CENTER_Y],
                                cfg_model[CFG_BOX_HEIGHT], cfg_model[CFG_IMAGE_HEIGHT]))
                begin
                    idx = {it.red, it.green, it.blue};
                    bin_model[idx] = sat_inc(bin_model[idx]);
                    total_model    = sat_inc(total_model);
                    pixels_counted++;
                end
            end
            KIND_READ:
            begin
                rd.bin_count   = bin_model[it.read_index];
                rd.pixel_total = total_model;
                expected_readings.push_back(rd);
            end
            default:
            begin
            end
        endcase
    endtask

    // sample transfers on the input and configuration channels
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                CFG_CENTER_X:     cfg_model[CFG_CENTER_X]     = int'(cfg_ch.data[10:0]);
                CFG_CENTER_Y:     cfg_model[CFG_CENTER_Y]     = int'(cfg_ch.data[10:0]);
                CFG_BOX_WIDTH:    cfg_model[CFG_BOX_WIDTH]    = int'(cfg_ch.data[10:0]);
                CFG_BOX_HEIGHT:   cfg_model[CFG_BOX_HEIGHT]   = int'(cfg_ch.data[10:0]);
                CFG_IMAGE_WIDTH:  cfg_model[CFG_IMAGE_WIDTH]  = int'(cfg_ch.data);
                CFG_IMAGE_HEIGHT: cfg_model[CFG_IMAGE_HEIGHT] = int'(cfg_ch.data);
                default:
                begin
                end
            endcase
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            hist_item_t it;
            it.kind       = in_ch.kind;
            it.col        = in_ch.col;
            it.row        = in_ch.row;
            it.fg         = in_ch.fg_mask;
            it.blue       = in_ch.blue_bin;
            it.green      = in_ch.green_bin;
            it.red        = in_ch.red_bin;
            it.read_index = in_ch.read_index;
            items_accepted++;
            predict_item(it);
        end
    end

    // check each result transfer against the oldest expected reading
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            bin_reading_t exp_rd;
            if (expected_readings.size() == 0)
            begin
                $error("result with no read outstanding: bin_count %0d pixel_total %0d",
                       out_ch.bin_count, out_ch.pixel_total);
                mismatches++;
            end
            else
            begin
                exp_rd = expected_readings.pop_front();
                reads_checked++;
                if (out_ch.bin_count !== exp_rd.bin_count)
                begin
                    $error("bin_count: expected %0d, actual %0d",
                           exp_rd.bin_count, out_ch.bin_count);
                    mismatches++;
                end
                if (out_ch.pixel_total !== exp_rd.pixel_total)
                begin
                    $error("pixel_total: expected %0d, actual %0d",
                           exp_rd.pixel_total, out_ch.pixel_total);
                    mismatches++;
                end
            end
        end
    end

    // item driver, fed from the pending queue
    always @(negedge clk)
    begin
        hist_item_t it;
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (pending_items.size() != 0
                && (steady || $urandom_range(99) >= IDLE_PERCENT))
            begin
                it = pending_items.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.kind       <= it.kind;
                in_ch.col        <= it.col;
                in_ch.row        <= it.row;
                in_ch.fg_mask    <= it.fg;
                in_ch.blue_bin   <= it.blue;
                in_ch.green_bin  <= it.green;
                in_ch.red_bin    <= it.red;
                in_ch.read_index <= it.read_index;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && reads_checked >= 20)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    function automatic hist_item_t make_pixel(int col, int row, bit fg,
                                              int blue, int green, int red);
        hist_item_t it;
        it.kind       = KIND_PIXEL;
        it.col        = col[10:0];
        it.row        = row[10:0];
        it.fg         = fg;
        it.blue       = blue[3:0];
        it.green      = green[3:0];
        it.red        = red[3:0];
        it.read_index = 12'($urandom);
        return it;
    endfunction

    function automatic hist_item_t make_op(logic [1:0] kind, int idx);
        hist_item_t it;
        it            = make_pixel($urandom_range(2047), $urandom_range(2047),
                                   $urandom_range(1), $urandom_range(15),
                                   $urandom_range(15), $urandom_range(15));
        it.kind       = kind;
        it.read_index = idx[11:0];
        return it;
    endfunction

    // coordinate around the clipped span, one step past each end
    function automatic int near_span(int c, int s, int lim);
        int lo;
        int hi;
        lo = c - s / 2;
        hi = c + s / 2;
        if (hi > lim - 1)
            hi = lim - 1;
        if (hi > 2047)
            hi = 2047;
        lo = (lo > 0) ? lo - 1 : 0;
        if (hi < lo)
            hi = lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic hist_item_t make_random_item();
        hist_item_t  it;
        int          pick;
        logic [11:0] colour;
        pick = $urandom_range(99);
        if (pick < 2)
            it = make_op(KIND_CLEAR, $urandom_range(4095));
        else if (pick < 8)
            it = make_op(KIND_UNUSED, $urandom_range(4095));
        else if (pick < 28)
            it = make_op(KIND_READ, ($urandom_range(9) < 7)
                                    ? int'(hot_bins[$urandom_range(7)])
                                    : $urandom_range(4095));
        else
        begin
            colour = $urandom_range(1) ? hot_bins[$urandom_range(7)] : 12'($urandom);
            if ($urandom_range(3) == 0)
                hot_bins[$urandom_range(7)] = colour;
            if ($urandom_range(99) < 85)
                it = make_pixel(near_span(stim_cfg[CFG_CENTER_X], stim_cfg[CFG_BOX_WIDTH],
                                          stim_cfg[CFG_IMAGE_WIDTH]),
                                near_span(stim_cfg[CFG_CENTER_Y], stim_cfg[CFG_BOX_HEIGHT],
                                          stim_cfg[CFG_IMAGE_HEIGHT]),
                                $urandom_range(9) != 0,
                                colour[3:0], colour[7:4], colour[11:8]);
            else
                it = make_pixel($urandom_range(2047), $urandom_range(2047),
                                $urandom_range(1), colour[3:0], colour[7:4], colour[11:8]);
        end
        return it;
    endfunction

    // write all six registers from stim_cfg, one transfer each
    task automatic write_config();
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= i[CFG_IDX_BITS-1:0];
            cfg_ch.data  <= stim_cfg[i][11:0];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(int cx, int cy, int bw, int bh, int iw, int ih);
        stim_cfg[CFG_CENTER_X]     = cx;
        stim_cfg[CFG_CENTER_Y]     = cy;
        stim_cfg[CFG_BOX_WIDTH]    = bw;
        stim_cfg[CFG_BOX_HEIGHT]   = bh;
        stim_cfg[CFG_IMAGE_WIDTH]  = iw;
        stim_cfg[CFG_IMAGE_HEIGHT] = ih;
    endtask

    task automatic set_random_config();
        int cx;
        int cy;
        cx = $urandom_range(2047);
        cy = $urandom_range(2047);
        set_config(cx, cy,
                   ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(64),
                   ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(64),
                   ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(2048, cx + 1),
                   ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(2048, cy + 1));
    endtask

    // wait for the block to drain, then let up to three queued clear sweeps run out
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_ch.valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        int queued;
        hist_item_t it;

        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_CLEAR;
        in_ch.col        = '0;
        in_ch.row        = '0;
        in_ch.fg_mask    = 1'b0;
        in_ch.blue_bin   = '0;
        in_ch.green_bin  = '0;
        in_ch.red_bin    = '0;
        in_ch.read_index = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_CENTER_X;
        cfg_ch.data      = '0;
        steady           = 1'b0;
        hold_done        = 1'b0;
        hold_left        = 0;
        in_taken         = 1'b0;
        for (int i = 0; i < 4096; i++)
            bin_model[i] = '0;
        total_model = '0;
        cfg_model[CFG_CENTER_X]     = 0;
        cfg_model[CFG_CENTER_Y]     = 0;
        cfg_model[CFG_BOX_WIDTH]    = 0;
        cfg_model[CFG_BOX_HEIGHT]   = 0;
        cfg_model[CFG_IMAGE_WIDTH]  = IMAGE_WIDTH_RESET;
        cfg_model[CFG_IMAGE_HEIGHT] = IMAGE_HEIGHT_RESET;
        for (int i = 0; i < 8; i++)
            hot_bins[i] = 12'($urandom);

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(100, 50, 20, 10, 640, 480);
                // box centred on the origin, clipped at the top left
                1: set_config(0, 0, 2047, 2047, 2048, 2048);
                // clipped at the bottom right, last column never counted
                2: set_config(2047, 2047, 2047, 2047, 2048, 2048);
                // image of one column and zero rows: nothing counted
                3: set_config(10, 10, 40, 40, 1, 0);
                // image larger than the coordinate range
                4: set_config(2047, 2047, 2047, 2047, 4095, 4095);
                // zero-sized box
                5: set_config(300, 300, 0, 0, 2048, 2048);
                // odd box sizes
                6: set_config(500, 700, 33, 1, 1024, 1024);
                default: set_random_config();
            endcase
            write_config();
            phases_run++;
            steady = (phase == 7);

            if (phase == 0)
            begin
                // directed items, box spans columns 90..109 and rows 45..54
                pending_items.push_back(make_op(KIND_READ, 0));
                pending_items.push_back(make_pixel(90, 45, 1, 15, 15, 15));
                pending_items.push_back(make_pixel(109, 54, 1, 5, 3, 9));
                pending_items.push_back(make_pixel(110, 50, 1, 5, 3, 9));
                pending_items.push_back(make_pixel(89, 50, 1, 5, 3, 9));
                pending_items.push_back(make_pixel(100, 55, 1, 5, 3, 9));
                pending_items.push_back(make_pixel(100, 44, 1, 5, 3, 9));
                pending_items.push_back(make_pixel(100, 50, 0, 5, 3, 9));
                pending_items.push_back(make_pixel(100, 50, 1, 0, 0, 0));
                pending_items.push_back(make_op(KIND_UNUSED, 0));
                pending_items.push_back(make_op(KIND_READ, 4095));
                pending_items.push_back(make_op(KIND_READ, 9 * 256 + 3 * 16 + 5));
                pending_items.push_back(make_op(KIND_READ, 0));
                pending_items.push_back(make_pixel(2047, 2047, 1, 1, 1, 1));
                pending_items.push_back(make_pixel(0, 0, 1, 1, 1, 1));
                pending_items.push_back(make_op(KIND_CLEAR, 4095));
                pending_items.push_back(make_op(KIND_READ, 4095));
                pending_items.push_back(make_pixel(95, 47, 1, 15, 0, 0));
                pending_items.push_back(make_op(KIND_READ, 15));
                pending_items.push_back(make_op(KIND_READ, 0));
            end
            if (phase == 1 || phase == 2 || phase == 4)
            begin
                // corner pixels of the coordinate range
                pending_items.push_back(make_pixel(0, 0, 1, 2, 2, 2));
                pending_items.push_back(make_pixel(2046, 2046, 1, 2, 2, 2));
                pending_items.push_back(make_pixel(2047, 2047, 1, 2, 2, 2));
                pending_items.push_back(make_op(KIND_READ, 2 * 256 + 2 * 16 + 2));
            end

            queued = 0;
            while (queued < ITEMS_PER_PHASE)
            begin
                it = make_random_item();
                pending_items.push_back(it);
                if (it.kind != KIND_UNUSED)
                    queued++;
            end
            wait_idle();
        end

        $display("%0d items over %0d register settings, %0d reads checked",
                 items_accepted, phases_run, reads_checked);
        $display("%0d pixels counted, %0d clears, %0d mismatches",
                 pixels_counted, clears_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
